// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the port-level checker (tws_check).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with an asynchronous active-low reset.
`define TWS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A signal holds its value over a cycle in which a beat is offered but not taken.
`define TWS_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

// ===== design/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants and beat types of the trie word store.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int ALPHABET_DEF  = 26;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_PREFIX = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [4:0] letter;
		logic       last;
	} letter_beat_t;

	typedef struct packed {
		logic [1:0] done_op;
		logic       found;
		logic       pool_full;
	} result_beat_t;

endpackage

`default_nettype wire

// ===== design/tws_chan_if.sv =====
// ----------------------------------------------------------------------------
// tws_chan_if
// Valid/ready channel carrying one payload beat of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface tws_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tws_ram.sv =====
// ----------------------------------------------------------------------------
// tws_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/trie_word_store.sv =====
// ----------------------------------------------------------------------------
// trie_word_store
// Trie over a small alphabet in a fixed node pool, fed one letter per beat.
// The letters channel carries op, letter and last; op is sampled on the first
// letter of a word. The results channel returns one beat per finished word:
// done_op, found and pool_full. A letter is taken only in the idle state; the
// child entry for (node, letter) is read from the child table RAM in the idle
// state and used in the lookup state, because the next address depends on that
// read. A finished search adds the mark state for the end mark RAM read. Letters
// after a missing path or a full pool skip the lookup and stay idle. After
// reset the block sweeps both RAMs to zero, one entry per cycle over the child
// table slots, with letters.ready low. Results sit in an output register; a last
// letter is held off while that register is full and not being taken, other letters flow on.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_store #(
	parameter int MAX_NODES = tws_pkg::MAX_NODES_DEF,
	parameter int ALPHABET  = tws_pkg::ALPHABET_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tws_chan_if.sink   letters,
	tws_chan_if.source results
);

	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int NEXT_W   = $clog2(MAX_NODES + 1);
	localparam int CODE_W   = $clog2(ALPHABET);
	localparam int SLOTS    = MAX_NODES * ALPHABET;
	localparam int SLOT_W   = $clog2(SLOTS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_MARK = 2'd2;

	logic [1:0]        state_q;
	logic              clr_q;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic              mid_q;
	logic              last_q;
	logic              failed_q;
	logic [1:0]        op_q;
	logic [NODE_W-1:0] walk_q;
	logic [NEXT_W-1:0] next_free_q;
	logic [SLOT_W-1:0] slot_q;
	logic              out_vld_q;
	tws_pkg::result_beat_t out_q;

	logic              in_fire;
	logic [1:0]        op_new;
	logic [1:0]        op_cur;
	logic              failed_cur;
	logic [NODE_W-1:0] walk_cur;
	logic [31:0]       letter_ext;
	logic [CODE_W-1:0] code;
	logic [SLOT_W-1:0] slot;

	logic [NODE_W-1:0] kid;
	logic              kid_hit;
	logic              can_alloc;
	logic              look_fail;
	logic              alloc;
	logic              mark_we;
	logic [NODE_W-1:0] new_walk;

	logic              child_we;
	logic [SLOT_W-1:0] child_waddr;
	logic [NODE_W-1:0] child_wdata;
	logic [NODE_W-1:0] child_rdata_w;
	logic              end_we;
	logic [NODE_W-1:0] end_waddr;
	logic              end_rdata;

	logic              res_set;
	tws_pkg::result_beat_t res_d;
	logic [1:0]        state_d;

	assign letters.ready = (state_q == S_IDLE) && !clr_q &&
		!(letters.data.last && out_vld_q && !results.ready);
	assign in_fire = letters.valid && letters.ready;

	always_comb begin
		op_new = (letters.data.op == tws_pkg::OP_INSERT ||
			letters.data.op == tws_pkg::OP_SEARCH) ? letters.data.op : tws_pkg::OP_PREFIX;
		op_cur     = mid_q ? op_q : op_new;
		failed_cur = mid_q && failed_q;
		walk_cur   = mid_q ? walk_q : '0;
		letter_ext = 32'(letters.data.letter);
		code = (letter_ext >= 32'(ALPHABET)) ? CODE_W'(ALPHABET - 1) : CODE_W'(letter_ext);
		slot = SLOT_W'(walk_cur) * SLOT_W'(ALPHABET) + SLOT_W'(code);
	end

	always_comb begin
		kid       = child_rdata_w;
		kid_hit   = (kid != '0);
		can_alloc = (next_free_q < NEXT_W'(MAX_NODES));
		look_fail = !kid_hit && !((op_q == tws_pkg::OP_INSERT) && can_alloc);
		alloc     = (state_q == S_LOOK) && !kid_hit && (op_q == tws_pkg::OP_INSERT) && can_alloc;
		new_walk  = kid_hit ? kid : next_free_q[NODE_W-1:0];
		mark_we   = (state_q == S_LOOK) && last_q && (op_q == tws_pkg::OP_INSERT) && !look_fail;
	end

	always_comb begin
		child_we    = clr_q || alloc;
		child_waddr = clr_q ? clr_cnt_q : slot_q;
		child_wdata = clr_q ? '0 : next_free_q[NODE_W-1:0];
		end_we      = (clr_q && (clr_cnt_q < SLOT_W'(MAX_NODES))) || mark_we;
		end_waddr   = clr_q ? clr_cnt_q[NODE_W-1:0] : new_walk;
	end

	tws_ram #(
		.WIDTH (NODE_W),
		.DEPTH (SLOTS)
	) u_child_ram (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.raddr (slot),
		.rdata (child_rdata_w)
	);

	tws_ram #(
		.WIDTH (1),
		.DEPTH (MAX_NODES)
	) u_end_ram (
		.clk   (clk),
		.we    (end_we),
		.waddr (end_waddr),
		.wdata (!clr_q),
		.raddr (new_walk),
		.rdata (end_rdata)
	);

	always_comb begin
		res_set = 1'b0;
		res_d   = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (failed_cur) begin
						if (letters.data.last) begin
							res_set           = 1'b1;
							res_d.done_op     = op_cur;
							res_d.pool_full   = (op_cur == tws_pkg::OP_INSERT);
						end
					end else begin
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
				if (last_q) begin
					res_d.done_op = op_q;
					if (op_q == tws_pkg::OP_INSERT) begin
						res_set         = 1'b1;
						res_d.found     = !look_fail;
						res_d.pool_full = look_fail;
					end else if (op_q == tws_pkg::OP_PREFIX) begin
						res_set     = 1'b1;
						res_d.found = !look_fail;
					end else if (look_fail) begin
						res_set = 1'b1;
					end else begin
						state_d = S_MARK;
					end
				end
			end
			S_MARK: begin
				res_set       = 1'b1;
				res_d.done_op = tws_pkg::OP_SEARCH;
				res_d.found   = end_rdata;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			mid_q       <= 1'b0;
			last_q      <= 1'b0;
			failed_q    <= 1'b0;
			op_q        <= tws_pkg::OP_INSERT;
			walk_q      <= '0;
			next_free_q <= NEXT_W'(1);
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
				if (clr_cnt_q == SLOT_W'(SLOTS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (in_fire) begin
				mid_q    <= !letters.data.last;
				last_q   <= letters.data.last;
				op_q     <= op_cur;
				failed_q <= failed_cur;
			end
			if (state_q == S_LOOK) begin
				walk_q   <= new_walk;
				failed_q <= look_fail;
			end
			if (alloc) begin
				next_free_q <= next_free_q + NEXT_W'(1);
			end
			if (res_set) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q <= slot;
		end
		if (res_set) begin
			out_q <= res_d;
		end
	end

	assign results.valid = out_vld_q;
	assign results.data  = out_q;

endmodule

`default_nettype wire

// ===== design/tws_check.sv =====
// ----------------------------------------------------------------------------
// tws_check
// Port-level assertions for the trie word store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tws_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] done_op,
	input wire logic       found,
	input wire logic       pool_full
);

	logic [3:0] out_beat;

	assign out_beat = {done_op, found, pool_full};

	`TWS_ASSERT_HOLD(a_out_valid_holds, clk, arst_n, out_valid, out_ready, out_valid, "result beat withdrawn")
	`TWS_ASSERT_HOLD(a_out_beat_holds, clk, arst_n, out_valid, out_ready, out_beat, "stalled result changed")
	`TWS_ASSERT(a_hit_or_full, clk, arst_n, out_valid |-> !(found && pool_full), "found and pool_full both set")
	`TWS_ASSERT(a_full_is_insert, clk, arst_n, (out_valid && pool_full) |-> (done_op == tws_pkg::OP_INSERT), "pool_full on a lookup")
	`TWS_ASSERT(a_no_overrun, clk, arst_n, (in_valid && in_ready && in_last) |-> (!out_valid || out_ready), "last letter taken while result stalled")

endmodule

bind trie_word_store tws_check u_tws_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (letters.valid),
	.in_ready  (letters.ready),
	.in_last   (letters.data.last),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.done_op   (results.data.done_op),
	.found     (results.data.found),
	.pool_full (results.data.pool_full)
);

`default_nettype wire

// ===== bench/tws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_checker
// Watches the letter and result channels of the trie word store. It keeps its
// own trie of the same size, updates it on every accepted letter beat, and
// compares each accepted result beat with the oldest answer it expects.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_checker
	import tws_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	tws_chan_if       letters,
	tws_chan_if       results,
	output int        fail_count,
	output int        pending
);

	localparam int NODE_W = $clog2(MAX_NODES_DEF);
	localparam int SLOTS  = MAX_NODES_DEF * ALPHABET_DEF;

	logic [NODE_W-1:0] kid_of [SLOTS];
	logic              word_end [MAX_NODES_DEF];
	logic [NODE_W:0]   free_node;
	logic [NODE_W-1:0] cur_node;
	logic              walk_dead;
	logic [1:0]        cur_op;
	logic              in_word;
	result_beat_t      answers_q [$];
	int                bad;

	task automatic walk_letter(input letter_beat_t b);
		logic [4:0]   code;
		int           slot;
		result_beat_t r;
		if (!in_word) begin
			cur_op    = (b.op > OP_PREFIX) ? OP_PREFIX : b.op;
			cur_node  = '0;
			walk_dead = 1'b0;
		end
		code = (b.letter >= ALPHABET_DEF) ? 5'(ALPHABET_DEF - 1) : b.letter;
		if (!walk_dead) begin
			slot = int'(cur_node) * ALPHABET_DEF + int'(code);
			if (kid_of[slot] != '0) begin
				cur_node = kid_of[slot];
			end else if (cur_op == OP_INSERT && free_node < MAX_NODES_DEF) begin
				kid_of[slot] = free_node[NODE_W-1:0];
				cur_node     = free_node[NODE_W-1:0];
				free_node    = free_node + 1'b1;
			end else begin
				walk_dead = 1'b1;
			end
		end
		in_word = !b.last;
		if (b.last) begin
			r.done_op   = cur_op;
			r.found     = 1'b0;
			r.pool_full = 1'b0;
			case (cur_op)
				OP_INSERT: begin
					if (walk_dead) begin
						r.pool_full = 1'b1;
					end else begin
						word_end[cur_node] = 1'b1;
						r.found            = 1'b1;
					end
				end
				OP_SEARCH: r.found = !walk_dead && word_end[cur_node];
				default:   r.found = !walk_dead;
			endcase
			answers_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_beat_t want;
		result_beat_t got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) kid_of[i] = '0;
			for (int i = 0; i < MAX_NODES_DEF; i++) word_end[i] = 1'b0;
			free_node = 1;
			cur_node  = '0;
			walk_dead = 1'b0;
			cur_op    = OP_INSERT;
			in_word   = 1'b0;
			answers_q.delete();
			bad       = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (results.valid && results.ready) begin
				got = results.data;
				if (answers_q.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%0t: result beat with no word pending: op %0d found %0d full %0d",
							$realtime, got.done_op, got.found, got.pool_full);
				end else begin
					want = answers_q.pop_front();
					if (got.done_op !== want.done_op || got.found !== want.found ||
							got.pool_full !== want.pool_full) begin
						bad++;
						if (bad <= 10)
							$display("%0t: result mismatch: expected op %0d found %0d full %0d, got op %0d found %0d full %0d",
								$realtime, want.done_op, want.found, want.pool_full,
								got.done_op, got.found, got.pool_full);
					end
				end
			end
			if (letters.valid && letters.ready) walk_letter(letters.data);
			fail_count <= bad;
			pending    <= answers_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives words into the trie word store one letter beat at a time: a short
// directed set of words, then random words built mostly from stored words,
// small-alphabet words and long fresh inserts that exhaust the node pool.
// Four phases set the random idling: none, sender only, receiver only, both;
// once, the receiver holds off for a long stretch. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import tws_pkg::*;

	localparam int         ITEMS       = 1900;
	localparam int         MAX_LEN     = 12;
	localparam int         KEEP        = 256;
	localparam int         LIMIT       = 400000;
	localparam int         HOLD_CYCLES = 400;
	localparam logic [1:0] OP_SPARE    = 2'd3;

	typedef logic [4:0] word_t [MAX_LEN];

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	int    cycles = 0;
	int    fails;
	int    pending;
	int    sent;
	int    send_idle_pct;
	int    recv_stall_pct;
	logic  hold_go;
	word_t kept_words [KEEP];
	int    kept_len [KEEP];
	int    kept_cnt;

	tws_chan_if #(.T(letter_beat_t)) letters ();
	tws_chan_if #(.T(result_beat_t)) results ();

	trie_word_store u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.letters (letters),
		.results (results)
	);

	tws_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.letters    (letters),
		.results    (results),
		.fail_count (fails),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_beat(input letter_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			letters.valid <= 1'b0;
			@(posedge clk);
		end
		letters.valid <= 1'b1;
		letters.data  <= b;
		@(posedge clk);
		while (!letters.ready) @(posedge clk);
	endtask

	task automatic send_word(input logic [1:0] op, input word_t w, input int len);
		letter_beat_t b;
		for (int i = 0; i < len; i++) begin
			b.op     = (i == 0) ? op : 2'($urandom_range(3));
			b.letter = w[i];
			b.last   = (i == len - 1);
			send_beat(b);
			sent++;
		end
		if (op == OP_INSERT) begin
			if (kept_cnt < KEEP) begin
				kept_words[kept_cnt] = w;
				kept_len[kept_cnt]   = len;
				kept_cnt++;
			end else begin
				kept_cnt = KEEP;
				kept_words[$urandom_range(KEEP - 1)] = w;
			end
		end
	endtask

	function automatic word_t mk(input logic [4:0] c0, input logic [4:0] c1 = 0,
			input logic [4:0] c2 = 0);
		word_t w;
		foreach (w[i]) w[i] = '0;
		w[0] = c0;
		w[1] = c1;
		w[2] = c2;
		return w;
	endfunction

	initial begin
		int hold_left;
		logic hold_used;
		hold_left     = 0;
		hold_used     = 1'b0;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		word_t      w;
		int         len;
		int         pick;
		int         r;
		logic [1:0] op;
		letters.valid  = 1'b0;
		letters.data   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go        = 1'b0;
		sent           = 0;
		kept_cnt       = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_word(OP_INSERT, mk(0), 1);
		send_word(OP_SEARCH, mk(0), 1);
		send_word(OP_SEARCH, mk(25), 1);
		send_word(OP_SPARE,  mk(31), 1);
		send_word(OP_INSERT, mk(31, 0), 2);
		send_word(OP_SEARCH, mk(25, 0), 2);
		send_word(OP_SPARE,  mk(25), 1);
		send_word(OP_SEARCH, mk(25), 1);
		send_word(OP_INSERT, mk(0), 1);
		send_word(OP_SEARCH, mk(0, 1, 2), 3);
		send_word(OP_INSERT, mk(2, 3, 16), 3);
		send_word(OP_PREFIX, mk(25, 0), 2);
		send_word(OP_PREFIX, mk(2, 3, 16), 3);

		while (sent < ITEMS) begin
			case (sent * 4 / ITEMS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			if (sent >= 150 && !hold_go) hold_go <= 1'b1;
			foreach (w[i]) w[i] = '0;
			r = $urandom_range(99);
			if (r < 40 && kept_cnt > 0) begin
				pick = $urandom_range(kept_cnt - 1);
				w    = kept_words[pick];
				len  = kept_len[pick];
				case ($urandom_range(3))
					0: len = $urandom_range(len, 1);
					1: begin
						if (len < MAX_LEN) begin
							w[len] = 5'($urandom_range(ALPHABET_DEF - 1));
							len++;
						end
					end
					default: ;
				endcase
				op = 2'($urandom_range(3));
			end else if (r < 65) begin
				len = $urandom_range(4, 1);
				for (int i = 0; i < len; i++) w[i] = 5'($urandom_range(3));
				op = ($urandom_range(1) != 0) ? OP_INSERT : 2'($urandom_range(3));
			end else begin
				len = $urandom_range(MAX_LEN, 8);
				for (int i = 0; i < len; i++)
					w[i] = ($urandom_range(15) == 0) ? 5'($urandom_range(31, ALPHABET_DEF))
						: 5'($urandom_range(ALPHABET_DEF - 1));
				op = ($urandom_range(4) != 0) ? OP_INSERT : 2'($urandom_range(3));
			end
			send_word(op, w, len);
		end
		letters.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
